// ===== design/p2sd_pkg.sv =====
// ----------------------------------------------------------------------------
// p2sd_pkg
// Widths and codes shared by the point to segment distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package p2sd_pkg;

  // coordinate format (signed, 16 fraction bits, the format is only carried)
  localparam int COORD_BITS = 24;
  localparam int DIST_BITS  = COORD_BITS + 1;

  // internal widths
  localparam int DIFF_W = COORD_BITS + 1;      // coordinate difference
  localparam int PROD_W = 2 * DIFF_W;          // signed product of two differences
  localparam int SUM_W  = PROD_W + 1;          // sum of two products
  localparam int LEN_W  = 2 * COORD_BITS + 2;  // squared length, unsigned
  localparam int CR_W   = LEN_W;               // cross product magnitude
  localparam int HALF_W = CR_W / 2;            // cross product split for squaring
  localparam int REM_W  = 2 * CR_W + 4;        // root remainder
  localparam int PACC_W = DIST_BITS + LEN_W + 1;

  // pipeline depth: diff, product, sum, partial square, load, one stage per root bit
  localparam int FRONT_STAGES = 5;
  localparam int NUM_STAGES   = FRONT_STAGES + DIST_BITS;

  typedef enum logic [1:0] {
    CASE_DEGEN    = 2'd0,
    CASE_START    = 2'd1,
    CASE_END      = 2'd2,
    CASE_INTERIOR = 2'd3
  } near_case_e;

endpackage

`default_nettype wire

// ===== design/point_to_segment_distance.sv =====
// ----------------------------------------------------------------------------
// point_to_segment_distance
// Truncated distance from a point to a segment, with the nearest-part code.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid_i / in_ready_o, six coords   | consumer
//  out     | out_valid_o / out_ready_i, dist, case | producer
//
//  one transaction per cycle while the output is not stalled; 5 arithmetic
//  stages and one stage per result bit of the 25-step restoring root
//  every stage has its own valid bit and holds only while the stage after it
//  is full and stalled, so bubbles close up under a stalled output
//  reset clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module point_to_segment_distance (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [p2sd_pkg::COORD_BITS-1:0]  point_x_i,
  input  logic signed [p2sd_pkg::COORD_BITS-1:0]  point_y_i,
  input  logic signed [p2sd_pkg::COORD_BITS-1:0]  seg_start_x_i,
  input  logic signed [p2sd_pkg::COORD_BITS-1:0]  seg_start_y_i,
  input  logic signed [p2sd_pkg::COORD_BITS-1:0]  seg_end_x_i,
  input  logic signed [p2sd_pkg::COORD_BITS-1:0]  seg_end_y_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic        [p2sd_pkg::DIST_BITS-1:0]   dist_res_o,
  output logic        [1:0]                       nearest_case_o
);
  import p2sd_pkg::*;

  localparam int NS = NUM_STAGES;

  // stage valid bits and load enables
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o = en[0];

  // stage 0: coordinate differences
  logic signed [DIFF_W-1:0] v1x_q, v1y_q, v2x_q, v2y_q, wx_q, wy_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      v1x_q <= DIFF_W'(point_x_i) - DIFF_W'(seg_start_x_i);
      v1y_q <= DIFF_W'(point_y_i) - DIFF_W'(seg_start_y_i);
      v2x_q <= DIFF_W'(seg_end_x_i) - DIFF_W'(seg_start_x_i);
      v2y_q <= DIFF_W'(seg_end_y_i) - DIFF_W'(seg_start_y_i);
      wx_q  <= DIFF_W'(point_x_i) - DIFF_W'(seg_end_x_i);
      wy_q  <= DIFF_W'(point_y_i) - DIFF_W'(seg_end_y_i);
    end
  end

  // stage 1: products
  logic signed [PROD_W-1:0] p_lx_q, p_ly_q, p_dx_q, p_dy_q, p_c1_q, p_c2_q;
  logic signed [PROD_W-1:0] p_ax_q, p_ay_q, p_ex_q, p_ey_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p_lx_q <= v2x_q * v2x_q;
      p_ly_q <= v2y_q * v2y_q;
      p_dx_q <= v1x_q * v2x_q;
      p_dy_q <= v1y_q * v2y_q;
      p_c1_q <= v1x_q * v2y_q;
      p_c2_q <= v1y_q * v2x_q;
      p_ax_q <= v1x_q * v1x_q;
      p_ay_q <= v1y_q * v1y_q;
      p_ex_q <= wx_q * wx_q;
      p_ey_q <= wy_q * wy_q;
    end
  end

  // stage 2: sums, case decision, cross product magnitude
  logic signed [SUM_W-1:0] len2_s, dot_s, cr_s, sq1_s, sq2_s, cr_abs;
  logic        [LEN_W-1:0] len2_u;
  near_case_e              kind_d;
  logic        [LEN_W-1:0] small_d;

  always_comb begin
    len2_s = SUM_W'(p_lx_q) + SUM_W'(p_ly_q);
    dot_s  = SUM_W'(p_dx_q) + SUM_W'(p_dy_q);
    cr_s   = SUM_W'(p_c1_q) - SUM_W'(p_c2_q);
    sq1_s  = SUM_W'(p_ax_q) + SUM_W'(p_ay_q);
    sq2_s  = SUM_W'(p_ex_q) + SUM_W'(p_ey_q);
    len2_u = len2_s[LEN_W-1:0];
    cr_abs = cr_s[SUM_W-1] ? -cr_s : cr_s;
    small_d = sq1_s[LEN_W-1:0];
    if (len2_u == '0) begin
      kind_d = CASE_DEGEN;
    end else if (dot_s[SUM_W-1]) begin
      kind_d = CASE_START;
    end else if (dot_s > SUM_W'(len2_u)) begin
      kind_d = CASE_END;
      small_d = sq2_s[LEN_W-1:0];
    end else begin
      kind_d = CASE_INTERIOR;
    end
  end

  near_case_e             kind2_q;
  logic       [LEN_W-1:0] small2_q, den2_q;
  logic       [CR_W-1:0]  cr2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      kind2_q  <= kind_d;
      small2_q <= small_d;
      den2_q   <= (kind_d == CASE_INTERIOR) ? len2_u : LEN_W'(1);
      cr2_q    <= cr_abs[CR_W-1:0];
    end
  end

  // stage 3: partial products of the squared cross product
  near_case_e               kind3_q;
  logic [LEN_W-1:0]         small3_q, den3_q;
  logic [2*HALF_W-1:0]      pp_hh_q, pp_hl_q, pp_ll_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      kind3_q  <= kind2_q;
      small3_q <= small2_q;
      den3_q   <= den2_q;
      pp_hh_q  <= cr2_q[CR_W-1:HALF_W] * cr2_q[CR_W-1:HALF_W];
      pp_hl_q  <= cr2_q[CR_W-1:HALF_W] * cr2_q[HALF_W-1:0];
      pp_ll_q  <= cr2_q[HALF_W-1:0] * cr2_q[HALF_W-1:0];
    end
  end

  // root pipeline storage, entry 0 is the load stage
  logic [REM_W-1:0]     rem_q  [0:DIST_BITS];
  logic [PACC_W-1:0]    pacc_q [0:DIST_BITS];
  logic [LEN_W-1:0]     den_q  [0:DIST_BITS];
  logic [DIST_BITS-1:0] d_q    [0:DIST_BITS];
  near_case_e           kind_q [0:DIST_BITS];

  // stage 4: assemble the radicand
  logic [REM_W-1:0] num_d;

  always_comb begin
    if (kind3_q == CASE_INTERIOR) begin
      num_d = (REM_W'(pp_hh_q) << (2 * HALF_W)) + (REM_W'(pp_hl_q) << (HALF_W + 1))
            + REM_W'(pp_ll_q);
    end else begin
      num_d = REM_W'(small3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[FRONT_STAGES-1]) begin
      rem_q[0]  <= num_d;
      pacc_q[0] <= '0;
      den_q[0]  <= den3_q;
      d_q[0]    <= '0;
      kind_q[0] <= kind3_q;
    end
  end

  // one result bit per stage: largest d with d*d*den <= num
  for (genvar j = 1; j <= DIST_BITS; j++) begin : g_root
    localparam int B = DIST_BITS - j;
    logic [REM_W-1:0] delta;
    logic             take;

    always_comb begin
      delta = (REM_W'(pacc_q[j-1]) << (B + 1)) + (REM_W'(den_q[j-1]) << (2 * B));
      take  = delta <= rem_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en[FRONT_STAGES-1+j]) begin
        den_q[j]  <= den_q[j-1];
        kind_q[j] <= kind_q[j-1];
        if (take) begin
          rem_q[j]  <= rem_q[j-1] - delta;
          pacc_q[j] <= pacc_q[j-1] + (PACC_W'(den_q[j-1]) << B);
          d_q[j]    <= d_q[j-1] | (DIST_BITS'(1) << B);
        end else begin
          rem_q[j]  <= rem_q[j-1];
          pacc_q[j] <= pacc_q[j-1];
          d_q[j]    <= d_q[j-1];
        end
      end
    end
  end

  // output
  assign out_valid_o    = v_q[NS-1];
  assign dist_res_o     = d_q[DIST_BITS];
  assign nearest_case_o = kind_q[DIST_BITS];

endmodule

`default_nettype wire

// ===== design/p2sd_checker.sv =====
// ----------------------------------------------------------------------------
// p2sd_checker
// Port-level checks of the point to segment distance block.
// ----------------------------------------------------------------------------
`default_nettype none

module p2sd_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_ready_o,
  input logic                                    out_valid_o,
  input logic                                    out_ready_i,
  input logic        [p2sd_pkg::DIST_BITS-1:0]   dist_res_o,
  input logic        [1:0]                       nearest_case_o
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

  // a free output side never blocks the input
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output side is free");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(dist_res_o) && $stable(nearest_case_o))
    else $error("stalled result changed");

endmodule

bind point_to_segment_distance p2sd_checker u_p2sd_checker (.*);

`default_nettype wire
